FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the voice RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent at the same edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mcov_pkg.sv
// ----------------------------------------------------------------------------
// mcov_pkg
// Constants, types and lookup tables for the MIDI oscillator voice.
// ----------------------------------------------------------------------------
package mcov_pkg;

   localparam int SAMPLE_RATE_HZ = 44100;
   localparam int PHASE_BITS     = 32;
   localparam int NOTE_COUNT     = 128;
   localparam int TOP_BITS       = 16;

   // item kinds
   localparam logic ITEM_MIDI = 1'b0;
   localparam logic ITEM_TICK = 1'b1;

   // code index numbers
   localparam logic [3:0] CIN_NOTE_OFF = 4'h8;
   localparam logic [3:0] CIN_NOTE_ON  = 4'h9;
   localparam logic [3:0] CIN_CTRL     = 4'hB;

   // commands, channel masked off
   localparam logic [7:0] CMD_MASK     = 8'hF0;
   localparam logic [7:0] CMD_NOTE_OFF = 8'h80;
   localparam logic [7:0] CMD_NOTE_ON  = 8'h90;
   localparam logic [7:0] CMD_CTRL     = 8'hB0;

   // controllers
   localparam logic [6:0] CC_VOLUME = 7'd7;
   localparam logic [6:0] CC_WAVE   = 7'd70;
   localparam logic [6:0] WAVE_SQUARE_MIN = 7'd42;
   localparam logic [6:0] WAVE_SAW_MIN    = 7'd84;

   localparam logic [6:0] VOLUME_RESET = 7'd80;
   localparam logic [6:0] NOTE_A4      = 7'd69;
   localparam logic signed [7:0] NO_NOTE = -8'sd1;

   typedef enum logic [1:0] {
      WAVE_TRIANGLE = 2'd0,
      WAVE_SQUARE   = 2'd1,
      WAVE_SAW      = 2'd2
   } wave_type;

   typedef logic [PHASE_BITS-1:0] phase_type;
   typedef phase_type step_rom_type [NOTE_COUNT];
   typedef logic [6:0] vol_rom_type [NOTE_COUNT];

   // shaper controls
   typedef struct packed {
      wave_type            wave;
      logic [TOP_BITS-1:0] phase_top;
      logic [13:0]         scale;
   } shape_ctl_type;

   typedef logic [31:0] ratio_type [12];
   localparam ratio_type SEMIS_RATIO = '{
      32'd1189207115, 32'd1259921050, 32'd1334839854, 32'd1414213562,
      32'd1498307077, 32'd1587401052, 32'd1681792831, 32'd1781797436,
      32'd1887748625, 32'd2000000000, 32'd2118926189, 32'd2244924097
   };

   localparam logic [63:0] STEP_DEN = 64'd390625 * 64'(SAMPLE_RATE_HZ);

   // phase increment per note, rounded half up
   function automatic step_rom_type build_step_rom();
      step_rom_type rom;
      logic [63:0]  num;
      logic [63:0]  q;
      logic [63:0]  r;
      int           oct;
      int           k;
      int           shifts;
      for (int n = 0; n < NOTE_COUNT; n++) begin
         oct    = n / 12;
         k      = n % 12;
         num    = 64'(SEMIS_RATIO[k]) * 64'd11;
         q      = num / STEP_DEN;
         r      = num % STEP_DEN;
         shifts = PHASE_BITS + oct - 11;
         for (int i = 0; i < 64; i++) begin
            if (i < shifts) begin
               q = q << 1;
               r = r << 1;
               if (r >= STEP_DEN) begin
                  r = r - STEP_DEN;
                  q = q | 64'd1;
               end
            end
         end
         rom[n] = PHASE_BITS'((q + 64'd1) >> 1);
      end
      return rom;
   endfunction

   // controller value to volume percent, truncated
   function automatic vol_rom_type build_vol_rom();
      vol_rom_type rom;
      for (int d = 0; d < NOTE_COUNT; d++) begin
         rom[d] = 7'((d * 100) / 127);
      end
      return rom;
   endfunction

   localparam step_rom_type STEP_ROM = build_step_rom();
   localparam vol_rom_type  VOL_ROM  = build_vol_rom();

endpackage

FILE: rtl/core/mcov_shaper.sv
// ----------------------------------------------------------------------------
// mcov_shaper
// Waveform shaping from the phase top bits and volume scaling of one sample.
// ----------------------------------------------------------------------------
module mcov_shaper (
   input  mcov_pkg::shape_ctl_type ctl,
   output logic signed [14:0]      sample
);

   logic signed [17:0] shape;
   logic [16:0]        mag;
   logic [30:0]        prod;
   logic [14:0]        scaled;

   always_comb begin
      case (ctl.wave)
         mcov_pkg::WAVE_TRIANGLE: begin
            if (!ctl.phase_top[15]) begin
               shape = signed'({1'b0, ctl.phase_top, 1'b0}) - 18'sd32768;
            end else begin
               shape = 18'sd98304 - signed'({1'b0, ctl.phase_top, 1'b0});
            end
         end
         mcov_pkg::WAVE_SQUARE: begin
            shape = ctl.phase_top[15] ? 18'sd32768 : -18'sd32768;
         end
         mcov_pkg::WAVE_SAW: begin
            shape = signed'({2'b00, ctl.phase_top}) - 18'sd32768;
         end
         default: begin
            shape = signed'({2'b00, ctl.phase_top}) - 18'sd32768;
         end
      endcase
      mag    = shape[17] ? 17'(-shape) : 17'(shape);
      prod   = 31'(mag) * 31'(ctl.scale);
      scaled = prod[29:15];
      sample = shape[17] ? -signed'(scaled) : signed'(scaled);
   end

endmodule

FILE: rtl/core/midi_controlled_oscillator_voice_top.sv
// ----------------------------------------------------------------------------
// midi_controlled_oscillator_voice_top
// Monophonic MIDI voice: phase accumulator oscillator with volume and wave.
// ----------------------------------------------------------------------------
// Use: req carries one word per item, either a USB-MIDI event packet
// (req_type 0) or a sample tick (req_type 1). Packets with code index 8, 9
// or 0xB drive note-on, note-off, volume (CC7) and wave (CC70); they give no
// rsp word. Each tick gives one rsp word: the sample plus gate, held note,
// volume and wave as they stood at that tick.
// Timing: a tick taken into the input register moves to the result register
// once no waiting result blocks it, and is then offered on rsp.
// Throughput: one item per cycle while no tick waits on a stalled result, set
// by the single-pass shaper and its one multiplier.
// Stall: while rsp_stall holds a waiting result, packets still drain; a
// tick waits in the input register with req_stall high until the waiting
// result is taken.
// Reset: synchronous; clears the valid bits of both registers, silences the
// gate, sets the A4 step, volume 80, triangle wave and no held note.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_controlled_oscillator_voice_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_type,
   input  logic [7:0]         req_cin_header,
   input  logic [7:0]         req_midi_status,
   input  logic [6:0]         req_data_one,
   input  logic [6:0]         req_data_two,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_sample,
   output logic               rsp_gate,
   output logic signed [7:0]  rsp_held_note,
   output logic [6:0]         rsp_volume_now,
   output logic [1:0]         rsp_wave_now
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_type_ff;
   logic [3:0] s1_cin_ff;
   logic [7:0] s1_status_ff;
   logic [6:0] s1_d1_ff;
   logic [6:0] s1_d2_ff;

   // voice state
   mcov_pkg::phase_type  phase_ff, phase_in;
   mcov_pkg::phase_type  step_ff, step_in;
   logic                 gate_ff, gate_in;
   logic [6:0]           volume_ff, volume_in;
   logic [13:0]          scale_ff, scale_in;
   mcov_pkg::wave_type   wave_ff, wave_in;
   logic signed [7:0]    note_ff, note_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [14:0]   sample_ff;
   logic                 gate_out_ff;
   logic signed [7:0]    note_out_ff;
   logic [6:0]           volume_out_ff;
   mcov_pkg::wave_type   wave_out_ff;

   logic                    out_busy;
   logic                    s1_tick;
   logic                    s1_fire;
   logic                    tick_fire;
   logic                    midi_fire;
   logic                    cin_ok;
   logic [7:0]              cmd;
   mcov_pkg::shape_ctl_type shape_ctl;
   logic signed [14:0]      shaped;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign s1_tick   = s1_type_ff == mcov_pkg::ITEM_TICK;
   assign s1_fire   = s1_valid_ff && (!s1_tick || !out_busy);
   assign tick_fire = s1_fire && s1_tick;
   assign midi_fire = s1_fire && !s1_tick;
   assign req_stall = s1_valid_ff && !s1_fire;

   assign cin_ok = (s1_cin_ff == mcov_pkg::CIN_NOTE_OFF)
                || (s1_cin_ff == mcov_pkg::CIN_NOTE_ON)
                || (s1_cin_ff == mcov_pkg::CIN_CTRL);
   assign cmd    = s1_status_ff & mcov_pkg::CMD_MASK;

   assign shape_ctl.wave      = wave_ff;
   assign shape_ctl.phase_top = phase_ff[mcov_pkg::PHASE_BITS-1 -: mcov_pkg::TOP_BITS];
   assign shape_ctl.scale     = scale_ff;

   mcov_shaper u_shaper (
      .ctl    (shape_ctl),
      .sample (shaped)
   );

   always_comb begin
      s1_valid_in = req_stall ? s1_valid_ff : req_valid;
      phase_in    = phase_ff;
      step_in     = step_ff;
      gate_in     = gate_ff;
      volume_in   = volume_ff;
      scale_in    = scale_ff;
      wave_in     = wave_ff;
      note_in     = note_ff;
      if (tick_fire) begin
         phase_in = gate_ff ? phase_ff + step_ff : '0;
      end
      if (midi_fire && cin_ok) begin
         case (cmd)
            mcov_pkg::CMD_NOTE_ON: begin
               if (s1_d2_ff != 7'd0) begin
                  step_in = mcov_pkg::STEP_ROM[s1_d1_ff];
                  gate_in = 1'b1;
                  note_in = signed'({1'b0, s1_d1_ff});
               end else begin
                  gate_in = 1'b0;
               end
            end
            mcov_pkg::CMD_NOTE_OFF: begin
               gate_in = 1'b0;
            end
            mcov_pkg::CMD_CTRL: begin
               if (s1_d1_ff == mcov_pkg::CC_VOLUME) begin
                  volume_in = mcov_pkg::VOL_ROM[s1_d2_ff];
                  scale_in  = 14'(mcov_pkg::VOL_ROM[s1_d2_ff]) * 14'd100;
               end else if (s1_d1_ff == mcov_pkg::CC_WAVE) begin
                  if (s1_d2_ff < mcov_pkg::WAVE_SQUARE_MIN) begin
                     wave_in = mcov_pkg::WAVE_TRIANGLE;
                  end else if (s1_d2_ff < mcov_pkg::WAVE_SAW_MIN) begin
                     wave_in = mcov_pkg::WAVE_SQUARE;
                  end else begin
                     wave_in = mcov_pkg::WAVE_SAW;
                  end
               end
            end
            default: begin
               gate_in = gate_ff;
            end
         endcase
      end
      if (tick_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         step_ff      <= mcov_pkg::STEP_ROM[mcov_pkg::NOTE_A4];
         gate_ff      <= 1'b0;
         volume_ff    <= mcov_pkg::VOLUME_RESET;
         scale_ff     <= 14'(mcov_pkg::VOLUME_RESET) * 14'd100;
         wave_ff      <= mcov_pkg::WAVE_TRIANGLE;
         note_ff      <= mcov_pkg::NO_NOTE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         gate_ff      <= gate_in;
         volume_ff    <= volume_in;
         scale_ff     <= scale_in;
         wave_ff      <= wave_in;
         note_ff      <= note_in;
      end
   end

   // hold the input word while stalled
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_type_ff   <= req_type;
         s1_cin_ff    <= req_cin_header[3:0];
         s1_status_ff <= req_midi_status;
         s1_d1_ff     <= req_data_one;
         s1_d2_ff     <= req_data_two;
      end
   end

   // capture the result word on a tick
   always_ff @(posedge clock) begin
      if (tick_fire) begin
         sample_ff     <= gate_ff ? shaped : 15'sd0;
         gate_out_ff   <= gate_ff;
         note_out_ff   <= note_ff;
         volume_out_ff <= volume_ff;
         wave_out_ff   <= wave_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = sample_ff;
   assign rsp_gate       = gate_out_ff;
   assign rsp_held_note  = note_out_ff;
   assign rsp_volume_now = volume_out_ff;
   assign rsp_wave_now   = wave_out_ff;

   `ASSERT_ALWAYS(a_scale_match, clock, reset,
      scale_ff == 14'(volume_ff) * 14'd100, "volume scale out of step")
   `ASSERT_IMPLY(a_gate_has_note, clock, reset, gate_ff, !note_ff[7],
      "gate open with no note held")
   `ASSERT_NEXT(a_silent_phase, clock, reset, tick_fire && !gate_ff, phase_ff == '0,
      "phase not cleared on a silent tick")
   `ASSERT_IMPLY(a_silent_sample, clock, reset, rsp_valid_ff && !gate_out_ff,
      sample_ff == 15'sd0, "sample nonzero with gate closed")

endmodule
